// ----- hw/rtl/sida_pkg.sv -----
package sida_pkg;

  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned OPND_W = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_COUNT  = 3'd4,
    CMD_DUMP   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_REMOVE = 3'd2,
    CELL_WRITE  = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] last_pos;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/sida_cell.sv -----
module sida_cell import sida_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned POS        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] left_q,
  input  logic [DATA_WIDTH-1:0] right_q,
  input  logic [DATA_WIDTH-1:0] head_q,
  output logic [DATA_WIDTH-1:0] q
);

  localparam bit               IN_RANGE = (POS < (2 ** LEN_W));
  localparam logic [LEN_W-1:0] POS_C    = LEN_W'(POS);

  logic [DATA_WIDTH-1:0] q_r;
  logic [DATA_WIDTH-1:0] q_nxt;
  logic [LEN_W-1:0]      idx_ext;
  logic                  active;

  assign idx_ext = LEN_W'(ctl.idx);
  assign active  = IN_RANGE && (POS_C < ctl.len);

  always_comb begin
    q_nxt = q_r;
    if (active) begin
      unique case (ctl.op)
        CELL_INSERT: begin
          if (POS_C == idx_ext) begin
            q_nxt = word;
          end else if (POS_C > idx_ext) begin
            q_nxt = left_q;
          end
        end
        CELL_REMOVE: begin
          if (POS_C == ctl.last_pos) begin
            q_nxt = '0;
          end else if (POS_C >= idx_ext) begin
            q_nxt = right_q;
          end
        end
        CELL_WRITE: begin
          if (POS_C == idx_ext) begin
            q_nxt = word;
          end
        end
        CELL_ROTATE: begin
          q_nxt = (POS_C == ctl.last_pos) ? head_q : right_q;
        end
        default: q_nxt = q_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ----- hw/rtl/shift_insert_delete_array.sv -----
// Shift-insert / shift-delete array of DEPTH signed words.
// Input channel (in_valid/in_ready) takes one command word: cmd, index and
// operand_value. Result channel (out_valid/out_ready) returns result_value,
// match_count, index_error and last. cfg_we/cfg_wdata set the active length.
// Insert, remove and write finish in the cycle of acceptance and give no
// result. An index at or beyond the active length gives one error result,
// registered and shown in the cycle after acceptance.
// Read, count and dump rotate the active part of the cell chain past cell 0,
// one element per cycle unless paused, and restore it once all have passed,
// busy until then. Read answers when the indexed element reaches cell 0, count
// after the last element, dump gives one result per element. The rotation
// pauses while a result the receiver has not taken blocks the next one.
// A new command word is taken when no scan runs and the result register is
// free or being taken in the same cycle.
// Reset clears every element to zero and sets the active length to 64.
module shift_insert_delete_array import sida_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [IDX_W-1:0]         in_index,
  input  logic signed [OPND_W-1:0] in_operand_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       out_result_value,
  output logic [CNT_W-1:0]         out_match_count,
  output logic                     out_index_error,
  output logic                     out_last,
  input  logic                     cfg_we,
  input  logic [LEN_W-1:0]         cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  localparam logic [LEN_W-1:0] DEPTH_CAP =
    (DEPTH > (2 ** LEN_W - 1)) ? {LEN_W{1'b1}} : LEN_W'(DEPTH);

  state_t                state_r, state_nxt;
  logic [LEN_W-1:0]      alen_r;
  logic [LEN_W-1:0]      step_r, step_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;

  logic                  out_valid_r;
  logic signed [31:0]    out_val_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic                  out_err_r;
  logic                  out_last_r;

  logic                  emit;
  logic signed [31:0]    e_val;
  logic [CNT_W-1:0]      e_cnt;
  logic                  e_err;
  logic                  e_last;

  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      last_pos;
  logic                  out_free;
  logic                  accept;
  logic                  idx_bad;
  logic                  indexed;
  logic                  at_end;
  logic                  want_emit;
  logic                  match;
  cmd_t                  in_cmd_e;
  logic [DATA_WIDTH-1:0] word_in;
  logic signed [DATA_WIDTH-1:0] head_s;
  logic signed [31:0]    head_out;
  cell_ctl_t             ctl;

  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [DATA_WIDTH-1:0] cell_l [DEPTH];
  logic [DATA_WIDTH-1:0] cell_r [DEPTH];

  assign len      = (alen_r > DEPTH_CAP) ? DEPTH_CAP : alen_r;
  assign last_pos = len - LEN_W'(1);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign in_cmd_e = cmd_t'(in_cmd);
  assign idx_bad  = (LEN_W'(in_index) >= len);
  assign indexed  = (in_cmd_e == CMD_READ) || (in_cmd_e == CMD_INSERT) ||
                    (in_cmd_e == CMD_REMOVE) || (in_cmd_e == CMD_WRITE);
  assign word_in  = DATA_WIDTH'(in_operand_value);
  assign head_s   = cell_q[0];
  assign head_out = 32'(head_s);
  assign match    = (cell_q[0] == word_r);
  assign at_end   = (step_r == last_pos);

  always_comb begin
    want_emit = 1'b0;
    case (cmd_r) inside
      CMD_DUMP:  want_emit = 1'b1;
      CMD_READ:  want_emit = (step_r == LEN_W'(idx_r));
      CMD_COUNT: want_emit = at_end;
      default:   want_emit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cnt_nxt      = cnt_r;
    cmd_nxt      = cmd_r;
    idx_nxt      = idx_r;
    word_nxt     = word_r;
    ctl.op       = CELL_HOLD;
    ctl.idx      = in_index;
    ctl.len      = len;
    ctl.last_pos = last_pos;
    emit         = 1'b0;
    e_val        = '0;
    e_cnt        = '0;
    e_err        = 1'b0;
    e_last       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (indexed && idx_bad) begin
            emit  = 1'b1;
            e_err = 1'b1;
          end else begin
            case (in_cmd_e) inside
              CMD_INSERT: ctl.op = CELL_INSERT;
              CMD_REMOVE: ctl.op = CELL_REMOVE;
              CMD_WRITE:  ctl.op = CELL_WRITE;
              CMD_READ, CMD_COUNT, CMD_DUMP: begin
                if (len == '0) begin
                  emit = (in_cmd_e == CMD_COUNT);
                end else begin
                  state_nxt = ST_SCAN;
                  step_nxt  = '0;
                  cnt_nxt   = '0;
                  cmd_nxt   = in_cmd_e;
                  idx_nxt   = in_index;
                  word_nxt  = word_in;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_SCAN: begin
        ctl.idx = idx_r;
        if (!want_emit || out_free) begin
          ctl.op   = CELL_ROTATE;
          step_nxt = step_r + LEN_W'(1);
          cnt_nxt  = cnt_r + CNT_W'(match);
          emit     = want_emit;
          e_val    = (cmd_r == CMD_COUNT) ? '0 : head_out;
          e_cnt    = (cmd_r == CMD_COUNT) ? cnt_nxt : '0;
          e_last   = (cmd_r == CMD_DUMP) ? at_end : 1'b1;
          if (at_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alen_r      <= LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        alen_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    cnt_r  <= cnt_nxt;
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    word_r <= word_nxt;
    if (emit) begin
      out_val_r  <= e_val;
      out_cnt_r  <= e_cnt;
      out_err_r  <= e_err;
      out_last_r <= e_last;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign cell_l[g] = '0;
    end else begin : g_mid_l
      assign cell_l[g] = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign cell_r[g] = '0;
    end else begin : g_mid_r
      assign cell_r[g] = cell_q[g+1];
    end
    sida_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .POS        (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .word    (word_in),
      .left_q  (cell_l[g]),
      .right_q (cell_r[g]),
      .head_q  (cell_q[0]),
      .q       (cell_q[g])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_match_count  = out_cnt_r;
  assign out_index_error  = out_err_r;
  assign out_last         = out_last_r;

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (step_r <= last_pos))
    else $error("scan step beyond active length");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |->
      (out_last_r && (out_cnt_r == '0) && (out_val_r == '0)))
    else $error("error result carries data");

  a_count_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_cnt_r != '0)) |-> ((out_val_r == '0) && out_last_r))
    else $error("count result carries an element value");

  a_no_scan_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> ((state_r == ST_IDLE) || (step_r != '0)))
    else $error("scan restarted without finishing");

endmodule

// ----- tb/sida_checker.sv -----
module sida_checker import sida_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [IDX_W-1:0]         in_index,
  input  logic signed [OPND_W-1:0] in_operand_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [31:0]       out_result_value,
  input  logic [CNT_W-1:0]         out_match_count,
  input  logic                     out_index_error,
  input  logic                     out_last,
  input  logic                     cfg_we,
  input  logic [LEN_W-1:0]         cfg_wdata,
  output int                       mismatches,
  output int                       pending,
  output int                       checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0]      value;
    logic [CNT_W-1:0] count;
    logic             err;
    logic             last;
  } result_t;

  logic [31:0]      shadow_store [DEPTH_DEF];
  logic [LEN_W-1:0] length_reg;
  result_t          expected_results [$];

  function automatic int used_length();
    return (length_reg > DEPTH_DEF) ? DEPTH_DEF : int'(length_reg);
  endfunction

  function automatic void push_result(logic [31:0] value, int count, logic err, logic last);
    result_t r;
    r.value = value;
    r.count = count[CNT_W-1:0];
    r.err   = err;
    r.last  = last;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                          logic [31:0] val);
    int len;
    int hits;
    int i;
    len = used_length();
    if (cmd <= CMD_WRITE && int'(idx) >= len) begin
      push_result('0, 0, 1'b1, 1'b1);
      return;
    end
    case (cmd)
      CMD_READ: begin
        push_result(shadow_store[idx], 0, 1'b0, 1'b1);
      end
      CMD_INSERT: begin
        for (i = len - 1; i > int'(idx); i--) shadow_store[i] = shadow_store[i-1];
        shadow_store[idx] = val;
      end
      CMD_REMOVE: begin
        for (i = int'(idx) + 1; i < len; i++) shadow_store[i-1] = shadow_store[i];
        shadow_store[len-1] = '0;
      end
      CMD_WRITE: begin
        shadow_store[idx] = val;
      end
      CMD_COUNT: begin
        hits = 0;
        for (i = 0; i < len; i++) if (shadow_store[i] == val) hits++;
        push_result('0, hits, 1'b0, 1'b1);
      end
      CMD_DUMP: begin
        for (i = 0; i < len; i++) push_result(shadow_store[i], 0, 1'b0, i == len - 1);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      length_reg = LEN_RESET;
      expected_results.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, got value 0x%0h %s%0d %s%0b %s%0b",
                   $time, out_result_value, "count ", out_match_count,
                   "err ", out_index_error, "last ", out_last);
        end else begin
          want = expected_results.pop_front();
          check_field("result_value", want.value, out_result_value);
          check_field("match_count", 32'(want.count), 32'(out_match_count));
          check_field("index_error", 32'(want.err), 32'(out_index_error));
          check_field("last", 32'(want.last), 32'(out_last));
          checked++;
        end
      end
      if (cfg_we) length_reg = cfg_wdata;
      if (in_valid && in_ready) predict_command(in_cmd, in_index, in_operand_value);
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/tb_shift_insert_delete_array.sv -----
module tb_shift_insert_delete_array import sida_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_WORDS   = 27;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd = '0;
  logic [IDX_W-1:0]         in_index = '0;
  logic signed [OPND_W-1:0] in_operand_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [31:0]       out_result_value;
  logic [CNT_W-1:0]         out_match_count;
  logic                     out_index_error;
  logic                     out_last;
  logic                     cfg_we = 1'b0;
  logic [LEN_W-1:0]         cfg_wdata = '0;

  int mismatches;
  int pending;
  int checked;
  int cycles = 0;
  int words_sent = 0;
  int settings_used = 1;
  int cur_len = 64;
  bit idling_on = 1'b1;

  shift_insert_delete_array u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_index         (in_index),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_match_count  (out_match_count),
    .out_index_error  (out_index_error),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  sida_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_index         (in_index),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_match_count  (out_match_count),
    .out_index_error  (out_index_error),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .pending          (pending),
    .checked          (checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= !(idling_on && $urandom_range(0, 99) < 8);
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx, logic [31:0] val);
    if (idling_on && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_index <= idx;
    in_operand_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_length(logic [LEN_W-1:0] len);
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_len = (len > DEPTH_DEF) ? DEPTH_DEF : int'(len);
    settings_used++;
  endtask

  // bias toward in-range indexes and a small value pool so counts hit
  task automatic random_word(output bit counted);
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [31:0]      val;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)       cmd = $urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B;
    else if (pick < 33) cmd = CMD_READ;
    else if (pick < 53) cmd = CMD_INSERT;
    else if (pick < 68) cmd = CMD_REMOVE;
    else if (pick < 86) cmd = CMD_WRITE;
    else if (pick < 95) cmd = CMD_COUNT;
    else                cmd = CMD_DUMP;
    if (cur_len > 0 && $urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, cur_len - 1));
    else idx = IDX_W'($urandom_range(0, 63));
    if ($urandom_range(0, 1)) val = $urandom;
    else val = 32'(int'($urandom_range(0, 6)) - 3);
    send_word(cmd, idx, val);
    counted = (cmd != CMD_UNUSED_A && cmd != CMD_UNUSED_B);
  endtask

  initial begin
    logic [LEN_W-1:0] phase_len [8];
    int n;
    bit counted;
    phase_len = '{7'd64, 7'd1, 7'd127, 7'd12, 7'd0, 7'd40, 7'd64, 7'd3};
    phase_len[7] = LEN_W'($urandom_range(1, 127));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(CMD_READ, 6'd0, 32'd0);
    send_word(CMD_READ, 6'd63, 32'd0);
    send_word(CMD_WRITE, 6'd0, 32'h7fffffff);
    send_word(CMD_WRITE, 6'd63, 32'h80000000);
    send_word(CMD_WRITE, 6'd5, 32'hffffffff);
    send_word(CMD_READ, 6'd0, 32'd0);
    send_word(CMD_READ, 6'd63, 32'd0);
    send_word(CMD_INSERT, 6'd0, 32'd123);
    send_word(CMD_READ, 6'd63, 32'd0);
    send_word(CMD_INSERT, 6'd63, 32'd77);
    send_word(CMD_READ, 6'd63, 32'd0);
    send_word(CMD_REMOVE, 6'd0, 32'd0);
    send_word(CMD_REMOVE, 6'd63, 32'd0);
    send_word(CMD_COUNT, 6'd0, 32'd0);
    send_word(CMD_COUNT, 6'd0, 32'hffffffff);
    send_word(CMD_DUMP, 6'd0, 32'd0);
    send_word(CMD_UNUSED_A, 6'd63, 32'hffffffff);
    send_word(CMD_UNUSED_B, 6'd0, 32'd0);

    write_length(7'd3);
    send_word(CMD_READ, 6'd3, 32'd0);
    send_word(CMD_INSERT, 6'd63, 32'd1);
    send_word(CMD_REMOVE, 6'd3, 32'd0);
    send_word(CMD_WRITE, 6'd3, 32'd5);
    send_word(CMD_COUNT, 6'd0, 32'd0);
    send_word(CMD_DUMP, 6'd0, 32'd0);

    write_length(7'd0);
    send_word(CMD_READ, 6'd0, 32'd0);
    send_word(CMD_COUNT, 6'd0, 32'd0);
    send_word(CMD_DUMP, 6'd0, 32'd0);

    write_length(7'd127);
    send_word(CMD_DUMP, 6'd0, 32'd0);
    send_word(CMD_READ, 6'd63, 32'd0);

    for (int p = 0; p < 8; p++) begin
      write_length(phase_len[p]);
      idling_on = (p != 2);
      n = 0;
      while (n < PHASE_WORDS) begin
        random_word(counted);
        if (counted) n++;
        // hold the sender until the block has answered everything
        if (p == 5 && n == PHASE_WORDS / 2 && counted) wait_results();
      end
    end
    idling_on = 1'b1;

    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d command words over %0d length settings, including zero and clamped",
             words_sent, settings_used);
    $display("lengths; %0d result words compared.", checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sida_pkg.sv
hw/rtl/sida_cell.sv
hw/rtl/shift_insert_delete_array.sv
tb/sida_checker.sv
tb/tb_shift_insert_delete_array.sv
